[rtl/core/sparse_table_range_max_unit_defines.svh]
// ----------------------------------------------------------------------------
// Sparse table range maximum: assertion macros
// Clocked on clk and disabled during rst; used by the top level only.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MAX_UNIT_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MAX_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/srmq_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse table range maximum: shared package
// Sizes, table entry and request types, controller states, pair compare.
// ----------------------------------------------------------------------------
package srmq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int NUM_LEVELS   = 11;
  localparam int VAL_W        = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int LVL_W        = $clog2(NUM_LEVELS);
  localparam int ADDR_W       = LVL_W + IDX_W;
  localparam int MEM_DEPTH    = NUM_LEVELS * MAX_ELEMENTS;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_ELEMENTS);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        pos;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic             err;
    logic [LVL_W-1:0] k;
    logic [IDX_W-1:0] r2;
  } span_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_BUILD_RD,
    ST_BUILD_GAP
  } state_t;

  // Returns b when b beats a (value first, then position), else a.
  function automatic entry_t pair_max(entry_t a, entry_t b);
    logic b_wins;
    b_wins = (b.val > a.val) || ((b.val == a.val) && (b.pos > a.pos));
    return b_wins ? b : a;
  endfunction

endpackage

[rtl/core/srmq_mem.sv]
// ----------------------------------------------------------------------------
// Sparse table range maximum: level table memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module srmq_mem (
  input  logic               clk,
  input  srmq_pkg::mem_req_t req,
  output srmq_pkg::entry_t   rdata_a,
  output srmq_pkg::entry_t   rdata_b
);
  import srmq_pkg::*;

  entry_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

[rtl/core/srmq_span.sv]
// ----------------------------------------------------------------------------
// Sparse table range maximum: query span decode
// Checks a range and finds the block level and the second block start.
// ----------------------------------------------------------------------------
module srmq_span (
  input  logic [srmq_pkg::IDX_W-1:0] left,
  input  logic [srmq_pkg::IDX_W-1:0] right,
  input  logic [srmq_pkg::CNT_W-1:0] n_act,
  input  logic                       built,
  output srmq_pkg::span_t            span
);
  import srmq_pkg::*;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] r2_wide;
  logic [LVL_W-1:0] k;

  assign len = {1'b0, right} - {1'b0, left} + CNT_W'(1);

  // Floor of log2 of the range length.
  always_comb begin
    k = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (len[b]) begin
        k = LVL_W'(b);
      end
    end
  end

  assign r2_wide = {1'b0, right} + CNT_W'(1) - (CNT_W'(1) << k);

  always_comb begin
    span.err = !built || (left > right) || ({1'b0, right} >= n_act);
    span.k   = k;
    span.r2  = r2_wide[IDX_W-1:0];
  end

endmodule

[rtl/core/srmq_ctrl.sv]
// ----------------------------------------------------------------------------
// Sparse table range maximum: controller
// Takes loads and queries, sequences the level build, forms results.
// ----------------------------------------------------------------------------
module srmq_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              func,
  input  logic signed [srmq_pkg::VAL_W-1:0] value,
  input  logic [srmq_pkg::IDX_W-1:0]        position,
  input  logic [srmq_pkg::IDX_W-1:0]        left,
  input  srmq_pkg::span_t                   span,
  input  logic                              cfg_valid,
  input  logic [srmq_pkg::CNT_W-1:0]        cfg_data,
  input  srmq_pkg::entry_t                  rdata_a,
  input  srmq_pkg::entry_t                  rdata_b,
  output logic                              busy,
  output logic                              cfg_ready,
  output logic [srmq_pkg::CNT_W-1:0]        n_act,
  output logic                              built,
  output srmq_pkg::mem_req_t                mem_req,
  output logic                              done,
  output logic signed [srmq_pkg::VAL_W-1:0] max_value,
  output logic [srmq_pkg::IDX_W-1:0]        max_position,
  output logic                              error
);
  import srmq_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n_last;
  logic [LVL_W-1:0]  lev;
  logic [LVL_W-1:0]  lev_nx;
  logic [IDX_W-1:0]  idx;
  logic              pend;
  logic [ADDR_W-1:0] wr_addr;
  logic              q_err;
  logic              accept;
  logic              cfg_write;
  logic              load_ok;
  logic              load_last;
  logic              last_idx;
  logic              more_levels;
  logic [CNT_W:0]    lev_span;
  logic [CNT_W-1:0]  j_sum;
  logic [IDX_W-1:0]  j_pos;
  entry_t            pick;

  // A count of zero acts as one, anything above the table size as the size.
  always_comb begin
    if (count == '0) begin
      n_act = CNT_W'(1);
    end else if (count > CNT_W'(MAX_ELEMENTS)) begin
      n_act = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_act = count;
    end
  end

  assign n_last    = n_act - CNT_W'(1);
  assign accept    = start && (state == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign load_ok   = ({1'b0, position} < n_act);
  assign load_last = ({1'b0, position} == n_last);
  assign last_idx  = ({1'b0, idx} == n_last);

  assign lev_nx      = lev + LVL_W'(1);
  assign lev_span    = (CNT_W + 1)'(1) << lev_nx;
  assign more_levels = (int'(lev_nx) < NUM_LEVELS) && (lev_span <= {1'b0, n_act});

  // Partner of entry idx one level down, clamped to the last element.
  assign j_sum = {1'b0, idx} + (CNT_W'(1) << (lev - LVL_W'(1)));
  assign j_pos = (j_sum > n_last) ? n_last[IDX_W-1:0] : j_sum[IDX_W-1:0];

  assign pick = pair_max(rdata_a, rdata_b);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_QUERY) begin
            state_next = ST_QUERY;
          end else if (load_ok && load_last && (n_act > CNT_W'(1))) begin
            state_next = ST_BUILD_RD;
          end
        end
      end
      ST_QUERY:     state_next = ST_IDLE;
      ST_BUILD_RD:  state_next = last_idx ? ST_BUILD_GAP : ST_BUILD_RD;
      ST_BUILD_GAP: state_next = more_levels ? ST_BUILD_RD : ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    cfg_ready       = 1'b0;
    mem_req.we      = pend;
    mem_req.waddr   = wr_addr;
    mem_req.wdata   = pick;
    mem_req.raddr_a = {lev - LVL_W'(1), idx};
    mem_req.raddr_b = {lev - LVL_W'(1), j_pos};
    unique case (state)
      ST_IDLE: begin
        busy            = 1'b0;
        cfg_ready       = 1'b1;
        mem_req.raddr_a = {span.k, left};
        mem_req.raddr_b = {span.k, span.r2};
        if (accept && (func == FUNC_LOAD) && load_ok) begin
          mem_req.we        = 1'b1;
          mem_req.waddr     = {LVL_W'(0), position};
          mem_req.wdata.val = value;
          mem_req.wdata.pos = position;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= COUNT_RESET;
      built <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
      lev   <= LVL_W'(1);
      idx   <= '0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_BUILD_RD);
      done  <= (state == ST_QUERY);
      if (cfg_write) begin
        count <= cfg_data;
        built <= 1'b0;
      end else if (accept && (func == FUNC_LOAD) && load_ok) begin
        // With a single element the last load leaves nothing to build.
        built <= load_last && (n_act == CNT_W'(1));
      end else if ((state == ST_BUILD_GAP) && !more_levels) begin
        built <= 1'b1;
      end
      if (accept) begin
        lev <= LVL_W'(1);
        idx <= '0;
      end else if ((state == ST_BUILD_RD) && !last_idx) begin
        idx <= idx + IDX_W'(1);
      end else if ((state == ST_BUILD_GAP) && more_levels) begin
        lev <= lev_nx;
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_err <= span.err;
    end
    if (state == ST_BUILD_RD) begin
      wr_addr <= {lev, idx};
    end
    if (state == ST_QUERY) begin
      error        <= q_err;
      max_value    <= q_err ? '0 : pick.val;
      max_position <= q_err ? '0 : pick.pos;
    end
  end

endmodule

[rtl/core/sparse_table_range_max_unit.sv]
// ----------------------------------------------------------------------------
// Sparse table range maximum unit
// A load word leaves busy low unless it is the load to the last position,
// with a count above one, which builds the levels: floor(log2 n) levels
// (at most ten), one table entry per cycle through the two read ports and
// the write port of the level memory, n being the element count. A query
// word keeps busy high while both blocks are read from the memory, and its
// result comes with done in the cycle after that, so a new word waits until
// busy falls. done lasts exactly one cycle and the receiver cannot hold it
// off. The count register is written through cfg while busy is low and
// clears the built table.
// ----------------------------------------------------------------------------
`include "sparse_table_range_max_unit_defines.svh"

module sparse_table_range_max_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic signed [srmq_pkg::VAL_W-1:0] value,
  input  logic [srmq_pkg::IDX_W-1:0]        position,
  input  logic [srmq_pkg::IDX_W-1:0]        left,
  input  logic [srmq_pkg::IDX_W-1:0]        right,
  output logic                              done,
  output logic signed [srmq_pkg::VAL_W-1:0] max_value,
  output logic [srmq_pkg::IDX_W-1:0]        max_position,
  output logic                              error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srmq_pkg::CNT_W-1:0]        cfg_data
);
  import srmq_pkg::*;

  span_t            span;
  mem_req_t         mem_req;
  entry_t           rdata_a;
  entry_t           rdata_b;
  logic [CNT_W-1:0] n_act;
  logic             built;

  srmq_span u_span (
    .left  (left),
    .right (right),
    .n_act (n_act),
    .built (built),
    .span  (span)
  );

  srmq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .value        (value),
    .position     (position),
    .left         (left),
    .span         (span),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .n_act        (n_act),
    .built        (built),
    .mem_req      (mem_req),
    .done         (done),
    .max_value    (max_value),
    .max_position (max_position),
    .error        (error)
  );

  srmq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // An accepted query is answered with done once the controller has passed its query state.
  `SRMQ_ASSERT_IMP(a_query_done, start && !busy && (func == FUNC_QUERY), ##2 done, "query result missing")
  // A query holds off the next word while its reads are in flight.
  `SRMQ_ASSERT_NXT(a_query_busy, start && !busy && (func == FUNC_QUERY), busy, "query not busy")
  // A load never produces a result word.
  `SRMQ_ASSERT_NXT(a_load_quiet, start && !busy && (func == FUNC_LOAD), !done, "result after load")
  // Results only appear once the controller is back to idle.
  `SRMQ_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")

endmodule
